/* design/lzwc_pkg.sv */
// Package for the LZW byte compressor: defaults, hash constants, the
// sequencer state type and the result item carried along the output cells.
// No dependencies.
package lzwc_pkg;

   localparam int CODE_BITS_DEF  = 12;
   localparam int DICT_SLOTS_DEF = 4096;
   localparam int FIRST_FREE     = 256;
   localparam int CODE_W         = 12;   // width of the result code field
   localparam int HASH_W         = 24;
   localparam logic [HASH_W-1:0] HASH_MUL_B = 24'd40503;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_MODDIV,
      ST_PROBE,
      ST_CHECK,
      ST_EMIT_MISS,
      ST_EMIT_LAST,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              last;
   } item_type;

endpackage

/* design/lzwc_dict.sv */
// Dictionary store of the LZW compressor: one write port, one read port
// with registered read data. Depends on lzwc_pkg.
module lzwc_dict import lzwc_pkg::*; #(
   parameter int DICT_SLOTS = DICT_SLOTS_DEF,
   parameter int ENTRY_W    = 33,
   parameter int SLOT_BITS  = $clog2(DICT_SLOTS)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]   wr_data,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic [ENTRY_W-1:0]   rd_data
);

   logic [ENTRY_W-1:0] mem_ff [DICT_SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lzwc_cell.sv */
// One cell of the result chain: holds one item, moves it towards the head
// on a pop and takes a new item when it is the first free cell.
// Depends on lzwc_pkg.
module lzwc_cell import lzwc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop,
   input  logic     push,
   input  item_type push_item,
   input  item_type next_item,    // contents of the cell behind this one
   input  logic     prev_filled,  // cell ahead is occupied after the shift
   output item_type cur_item,
   output logic     filled
);

   item_type item_ff, item_in, shifted;

   always_comb begin
      shifted = pop ? next_item : item_ff;
      item_in = shifted;
      if (push && !shifted.valid && prev_filled) begin
         item_in = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.code <= item_in.code;
      item_ff.last <= item_in.last;
   end

   assign cur_item = item_ff;
   assign filled   = shifted.valid;

endmodule

/* design/lzw_byte_compressor.sv */
// Top level of the LZW byte compressor: probe sequencer, dictionary store
// and a chain of result cells. Depends on lzwc_pkg, lzwc_dict, lzwc_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid req_stall req_data_byte        | in
//          | req_end_of_stream                       |
//  rsp     | rsp_valid rsp_stall rsp_code rsp_last_code | out
//
// A byte passes accept, hash, read and check on a hit, plus emit on a miss;
// each further probe past a slot taken by another string adds a read and a
// check, as the memory read port sets the probe step. The first byte of a
// stream is only accepted, a last byte adds an emit step for its final code.
// A table size that is not a power of two adds a quotient estimate step and
// a remainder step per byte. After reset and after every last byte the store
// is swept clear, one slot a cycle, while req_stall is held high.
// Results wait in a two-cell chain; a stalled rsp only holds the sequencer
// when both cells are full.
module lzw_byte_compressor import lzwc_pkg::*; #(
   parameter int CODE_BITS  = CODE_BITS_DEF,
   parameter int DICT_SLOTS = DICT_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_stream,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_code,
   output logic              rsp_last_code
);

   localparam int SLOT_BITS = $clog2(DICT_SLOTS);
   localparam int ENTRY_W   = 1 + 2 * CODE_BITS + 8;
   localparam bit IS_POW2   = (DICT_SLOTS & (DICT_SLOTS - 1)) == 0;
   localparam int CELLS     = 2;
   // reciprocal of the table size, scaled so it fits 16 bits
   localparam int          RECIP_P = SLOT_BITS + 7;
   localparam logic [15:0] RECIP_M = 16'((64'd1 << (SLOT_BITS + 15)) / 64'(DICT_SLOTS));

   // state
   state_type state_ff, state_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 eos_ff, eos_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 present_ff, present_in;
   logic [CODE_BITS:0]   next_free_ff, next_free_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS:0]   probes_ff, probes_in;
   logic [HASH_W-1:0]    hashv_ff, hashv_in;
   logic [15:0]          qest_ff, qest_in;
   logic                 mstep_ff, mstep_in;
   logic                 free_ff, free_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;

   // dictionary port
   logic                 wr_en;
   logic [SLOT_BITS-1:0] wr_addr;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   logic                 rd_valid;
   logic [CODE_BITS-1:0] rd_prefix, rd_code;
   logic [7:0]           rd_byte;

   // result chain
   item_type cell_item [CELLS];
   logic     cell_filled [CELLS];
   logic     pop, push;
   item_type push_item;
   logic     space;

   logic [HASH_W-1:0] h_pre, h_byte;
   logic [31:0]       prod;
   logic [31:0]       rwide;

   assign {rd_valid, rd_prefix, rd_byte, rd_code} = rd_data;

   assign pop   = cell_item[0].valid && !rsp_stall;
   assign space = !cell_item[CELLS-1].valid;

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         prefix_ff    <= '0;
         present_ff   <= 1'b0;
         next_free_ff <= (CODE_BITS + 1)'(FIRST_FREE);
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         present_ff   <= present_in;
         next_free_ff <= next_free_in;
         clr_ff       <= clr_in;
      end
      byte_ff   <= byte_in;
      eos_ff    <= eos_in;
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      hashv_ff  <= hashv_in;
      qest_ff   <= qest_in;
      mstep_ff  <= mstep_in;
      free_ff   <= free_in;
   end

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      eos_in       = eos_ff;
      prefix_in    = prefix_ff;
      present_in   = present_ff;
      next_free_in = next_free_ff;
      slot_in      = slot_ff;
      probes_in    = probes_ff;
      hashv_in     = hashv_ff;
      qest_in      = qest_ff;
      mstep_in     = mstep_ff;
      free_in      = free_ff;
      clr_in       = clr_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = {1'b1, prefix_ff, byte_ff, next_free_ff[CODE_BITS-1:0]};
      push         = 1'b0;
      push_item    = '{valid: 1'b1, code: CODE_W'(prefix_ff), last: 1'b0};
      h_pre        = HASH_W'(prefix_ff);
      h_byte       = HASH_W'(byte_ff) * HASH_MUL_B;
      prod         = '0;
      rwide        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               eos_in  = req_end_of_stream;
               if (!present_ff) begin
                  // first byte of a stream just becomes the prefix
                  prefix_in  = CODE_BITS'(req_data_byte);
                  present_in = 1'b1;
                  state_in   = req_end_of_stream ? ST_EMIT_LAST : ST_IDLE;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            hashv_in  = ((h_pre << 8) + h_pre) ^ h_byte;
            probes_in = '0;
            if (IS_POW2) begin
               slot_in  = hashv_in[SLOT_BITS-1:0];
               state_in = ST_PROBE;
            end else begin
               mstep_in = 1'b0;
               state_in = ST_MODDIV;
            end
         end
         ST_MODDIV: begin
            if (!mstep_ff) begin
               // quotient estimate from the upper hash bits, at most one short
               prod     = 32'(hashv_ff[HASH_W-1:8]) * 32'(RECIP_M);
               qest_in  = 16'(prod >> RECIP_P);
               mstep_in = 1'b1;
            end else begin
               rwide = 32'(hashv_ff) - 32'(qest_ff) * 32'(DICT_SLOTS);
               if (rwide >= 32'(DICT_SLOTS)) begin
                  rwide = rwide - 32'(DICT_SLOTS);
               end
               if (rwide >= 32'(DICT_SLOTS)) begin
                  rwide = rwide - 32'(DICT_SLOTS);
               end
               slot_in  = rwide[SLOT_BITS-1:0];
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            probes_in = probes_ff + 1'b1;
            if (!rd_valid) begin
               free_in  = 1'b1;
               state_in = ST_EMIT_MISS;
            end else if (rd_prefix == prefix_ff && rd_byte == byte_ff) begin
               prefix_in = rd_code;
               state_in  = eos_ff ? ST_EMIT_LAST : ST_IDLE;
            end else if (probes_in == (SLOT_BITS + 1)'(DICT_SLOTS)) begin
               free_in  = 1'b0;
               state_in = ST_EMIT_MISS;
            end else begin
               slot_in  = (slot_ff == SLOT_BITS'(DICT_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_EMIT_MISS: begin
            if (space) begin
               push = 1'b1;
               if (free_ff && !next_free_ff[CODE_BITS]) begin
                  wr_en        = 1'b1;
                  next_free_in = next_free_ff + 1'b1;
               end
               prefix_in = CODE_BITS'(byte_ff);
               state_in  = eos_ff ? ST_EMIT_LAST : ST_IDLE;
            end
         end
         ST_EMIT_LAST: begin
            push_item.last = 1'b1;
            if (space) begin
               push         = 1'b1;
               prefix_in    = '0;
               present_in   = 1'b0;
               next_free_in = (CODE_BITS + 1)'(FIRST_FREE);
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SLOT_BITS'(DICT_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   lzwc_dict #(
      .DICT_SLOTS (DICT_SLOTS),
      .ENTRY_W    (ENTRY_W),
      .SLOT_BITS  (SLOT_BITS)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // result chain: cell 0 is the head that drives rsp
   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      item_type next_item;
      logic     prev_filled;
      if (g == CELLS - 1) begin : g_tail
         assign next_item = '0;
      end else begin : g_mid
         assign next_item = cell_item[g+1];
      end
      if (g == 0) begin : g_head
         assign prev_filled = 1'b1;
      end else begin : g_rest
         assign prev_filled = cell_filled[g-1];
      end
      lzwc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .pop         (pop),
         .push        (push),
         .push_item   (push_item),
         .next_item   (next_item),
         .prev_filled (prev_filled),
         .cur_item    (cell_item[g]),
         .filled      (cell_filled[g])
      );
   end

   assign rsp_valid     = cell_item[0].valid;
   assign rsp_code      = cell_item[0].code;
   assign rsp_last_code = cell_item[0].last;

endmodule

/* tb/lzw_byte_compressor_test.sv */
// Self-checking testbench for lzw_byte_compressor: an LZW dictionary scoreboard
// predicts the code items, and tasks drive byte streams with random idling.
// Depends on lzwc_pkg and the design's top level.
`timescale 1ns / 100ps

class lzw_scoreboard;
   localparam int SLOTS = 4096;
   localparam int LIMIT = 1 << 12;

   bit          slot_used [SLOTS];
   int unsigned slot_pre  [SLOTS];
   bit [7:0]    slot_byte [SLOTS];
   int unsigned slot_code [SLOTS];
   int unsigned next_code;
   int unsigned cur_prefix;
   bit          have_prefix;
   bit [12:0]   expected_codes [$];   // {code, last}
   int          mismatches;
   int          checked;
   int          dict_full_seen;

   function new();
      mismatches = 0;
      checked = 0;
      dict_full_seen = 0;
      clear();
   endfunction

   function void clear();
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
      next_code = 256;
      cur_prefix = 0;
      have_prefix = 0;
   endfunction

   function int pending();
      return expected_codes.size();
   endfunction

   // One accepted byte: walk the dictionary and queue the codes it emits.
   function void note_byte(bit [7:0] b, bit eos);
      int unsigned s;
      int unsigned free_slot;
      bit hit;
      if (!have_prefix) begin
         cur_prefix = 32'(b);
         have_prefix = 1;
      end else begin
         s = (((cur_prefix * 257) ^ (b * 40503)) & 24'hFFFFFF) % SLOTS;
         free_slot = SLOTS;
         hit = 0;
         for (int n = 0; n < SLOTS; n++) begin
            if (!slot_used[s]) begin
               free_slot = s;
               break;
            end
            if (slot_pre[s] == cur_prefix && slot_byte[s] == b) begin
               hit = 1;
               break;
            end
            s = (s + 1) % SLOTS;
         end
         if (hit) begin
            cur_prefix = slot_code[s] & (LIMIT - 1);
         end else begin
            expected_codes.insert(expected_codes.size(), {cur_prefix[11:0], 1'b0});
            if (next_code < LIMIT && free_slot < SLOTS) begin
               slot_used[free_slot] = 1;
               slot_pre[free_slot]  = cur_prefix;
               slot_byte[free_slot] = b;
               slot_code[free_slot] = next_code;
               next_code++;
            end else begin
               dict_full_seen++;
            end
            cur_prefix = 32'(b);
         end
      end
      if (eos) begin
         expected_codes.insert(expected_codes.size(), {cur_prefix[11:0], 1'b1});
         clear();
      end
   endfunction

   function void check_code(bit [11:0] code, bit last);
      bit [12:0] exp_item;
      checked++;
      if (expected_codes.size() == 0) begin
         $error("unexpected code item: code %0d last_code %0d", code, last);
         mismatches++;
         return;
      end
      exp_item = expected_codes.pop_front();
      if (exp_item[12:1] != code) begin
         $error("code: expected %0d, actual %0d", exp_item[12:1], code);
         mismatches++;
      end
      if (exp_item[0] != last) begin
         $error("last_code: expected %0d, actual %0d", exp_item[0], last);
         mismatches++;
      end
   endfunction
endclass

module lzw_byte_compressor_test;
   import lzwc_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 0;
   logic              req_end_of_stream = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [CODE_W-1:0] rsp_code;
   logic              rsp_last_code;

   lzw_scoreboard sb = new();

   int  send_gap_pct = 0;    // sender idle, percent of cycles
   int  stall_pct    = 0;    // receiver stall, percent of cycles
   bit  hold_req     = 0;    // toggled by the stimulus to start a long hold-off
   bit  hold_seen    = 0;
   int  hold_left    = 0;
   int  items_sent   = 0;
   int  streams_sent = 0;

   lzw_byte_compressor dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Result side: check accepted items, then pick the stall for the next cycle.
   // A long hold-off is counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_code(rsp_code, rsp_last_code);
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 600;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one byte and wait for it to be taken. Valid stays high into the
   // next item when there is no gap, so it never drops and rises in one step.
   task automatic send_byte(input bit [7:0] b, input bit eos);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_gap_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, eos);
      items_sent++;
      if (eos) streams_sent++;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      if (req_valid) req_valid <= 0;
      while (sb.pending() > 0) begin
         @(posedge clock);
         guard++;
         if (guard > 400000) begin
            $display("tb: failure");
            $finish;
         end
      end
   endtask

   // Random stream: mostly a narrow alphabet so strings repeat and the
   // dictionary chains get deep, sometimes the whole byte range.
   task automatic send_stream(input int len);
      bit [7:0] alpha [4];
      bit wide;
      bit [7:0] b;
      wide = ($urandom_range(99) < 25);
      for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
      for (int i = 0; i < len; i++) begin
         b = wide ? 8'($urandom) : alpha[$urandom_range(3)];
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic random_phase(input int gap_pct, input int st_pct, input int budget);
      int used;
      int len;
      send_gap_pct = gap_pct;
      stall_pct = st_pct;
      used = 0;
      while (used < budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
         send_stream(len);
         used += len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed: single-byte streams at both byte extremes.
      send_byte(8'h00, 1);
      send_byte(8'hFF, 1);
      // Repeated byte: hits build up, final byte hits so a single final code closes it.
      for (int i = 0; i < 6; i++) send_byte(8'h41, i == 5);
      // Two streams of alternating bytes, each ending on a hit.
      for (int i = 0; i < 7; i++) send_byte(i[0] ? 8'h55 : 8'hAA, i == 6);
      for (int i = 0; i < 4; i++) send_byte(i[0] ? 8'h80 : 8'h7F, i == 3);
      wait_drained();

      // Pressure: long receiver hold-off while bytes keep coming.
      hold_req = ~hold_req;
      send_stream(40);
      wait_drained();

      // One longer stream of wide bytes, mostly misses, so the dictionary grows.
      send_gap_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 120; i++) send_byte(8'($urandom), i == 119);
      wait_drained();

      random_phase(0, 0, 80);
      // Sender pauses until everything is out, then resumes.
      wait_drained();
      random_phase(53, 0, 80);
      random_phase(0, 53, 80);
      random_phase(30, 30, 80);
      wait_drained();
      // Room for the store sweep that follows the last stream.
      repeat (4500) @(posedge clock);

      $display("covered %0d bytes in %0d streams, %0d code items checked",
               items_sent, streams_sent, sb.checked);
      $display("misses with the dictionary full: %0d", sb.dict_full_seen);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("tb: failure");
      $finish;
   end
endmodule

/* files.f */
design/lzwc_pkg.sv
design/lzwc_dict.sv
design/lzwc_cell.sv
design/lzw_byte_compressor.sv
tb/lzw_byte_compressor_test.sv
